// ----- rtl/sitrd_pkg.sv -----
// ----------------------------------------------------------------------------
// sitrd_pkg: shared types, constants and microprogram
// Widths, character codes, control word layout and the sequencer program
// for the signed integer to radix digits converter.
// ----------------------------------------------------------------------------
package sitrd_pkg;

	localparam int VALUE_W         = 32;
	localparam int SYM_W           = 8;
	localparam int NSYM            = 16;
	localparam int DIGIT_W         = 4;
	localparam int RADIX_W         = 5;
	localparam int CFG_W           = 64;
	localparam int CFG_IDX_W       = 2;
	localparam int STACK_DEPTH     = 32;
	localparam int STACK_AW        = 5;
	localparam int COUNT_W         = 6;
	localparam int DIV_BITS        = 8;
	localparam int DIV_CHUNKS      = VALUE_W / DIV_BITS;
	localparam int CHUNK_W         = 2;
	localparam int MAX_SYMBOLS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

	localparam int PC_W   = 4;
	localparam int OP_W   = 4;
	localparam int JUMP_W = 3;

	localparam logic [OP_W-1:0] OP_WAIT_IN     = 4'd0;
	localparam logic [OP_W-1:0] OP_CLEAR       = 4'd1;
	localparam logic [OP_W-1:0] OP_NOP         = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV_INIT    = 4'd3;
	localparam logic [OP_W-1:0] OP_DIV         = 4'd4;
	localparam logic [OP_W-1:0] OP_PUSH        = 4'd5;
	localparam logic [OP_W-1:0] OP_EMIT_SIGN   = 4'd6;
	localparam logic [OP_W-1:0] OP_POP         = 4'd7;
	localparam logic [OP_W-1:0] OP_EMIT_DIGIT  = 4'd8;

	localparam logic [JUMP_W-1:0] J_NEXT        = 3'd0;
	localparam logic [JUMP_W-1:0] J_ALWAYS      = 3'd1;
	localparam logic [JUMP_W-1:0] J_INVALID     = 3'd2;
	localparam logic [JUMP_W-1:0] J_CHUNK_MORE  = 3'd3;
	localparam logic [JUMP_W-1:0] J_MORE_DIGITS = 3'd4;
	localparam logic [JUMP_W-1:0] J_POSITIVE    = 3'd5;
	localparam logic [JUMP_W-1:0] J_EMPTY       = 3'd6;

	localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd3;
	localparam logic [PC_W-1:0] PC_DIV      = 4'd4;
	localparam logic [PC_W-1:0] PC_POP      = 4'd8;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [JUMP_W-1:0] jump;
		logic [PC_W-1:0]   target;
	} uword_t;

	typedef struct packed {
		logic [RADIX_W-1:0] rem;
		logic [DIV_BITS-1:0] quo;
	} div_res_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			4'd0:    w = '{OP_WAIT_IN,    J_NEXT,        PC_IDLE};
			4'd1:    w = '{OP_CLEAR,      J_NEXT,        PC_IDLE};
			4'd2:    w = '{OP_NOP,        J_INVALID,     PC_IDLE};
			4'd3:    w = '{OP_DIV_INIT,   J_NEXT,        PC_IDLE};
			4'd4:    w = '{OP_DIV,        J_CHUNK_MORE,  PC_DIV};
			4'd5:    w = '{OP_PUSH,       J_MORE_DIGITS, PC_DIV_INIT};
			4'd6:    w = '{OP_NOP,        J_POSITIVE,    PC_POP};
			4'd7:    w = '{OP_EMIT_SIGN,  J_NEXT,        PC_IDLE};
			4'd8:    w = '{OP_POP,        J_EMPTY,       PC_IDLE};
			4'd9:    w = '{OP_EMIT_DIGIT, J_ALWAYS,      PC_POP};
			default: w = '{OP_NOP,        J_ALWAYS,      PC_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic alphabet_ok(input logic [RADIX_W-1:0] n,
			input logic [NSYM*SYM_W-1:0] syms, input logic [RADIX_W-1:0] max_sym);
		logic ok;
		logic [SYM_W-1:0] si;
		ok = (n >= 5'd2) && (n <= max_sym) && (n <= 5'(NSYM));
		for (int i = 0; i < NSYM; i++) begin
			si = syms[i*SYM_W +: SYM_W];
			if (5'(i) < n) begin
				if (si == CH_PLUS || si == CH_MINUS)
					ok = 1'b0;
				for (int j = i + 1; j < NSYM; j++) begin
					if (5'(j) < n && syms[j*SYM_W +: SYM_W] == si)
						ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

endpackage

// ----- rtl/sitrd_div_chunk.sv -----
// ----------------------------------------------------------------------------
// sitrd_div_chunk: restoring division over one chunk of dividend bits
// Shifts a chunk of dividend bits through the partial remainder against a
// small radix and returns the quotient bits and the new remainder.
// ----------------------------------------------------------------------------
module sitrd_div_chunk (
	input  logic [sitrd_pkg::DIGIT_W-1:0]  rem_in,
	input  logic [sitrd_pkg::DIV_BITS-1:0] bits,
	input  logic [sitrd_pkg::RADIX_W-1:0]  radix,
	output sitrd_pkg::div_res_t            res
);

	always_comb begin
		logic [sitrd_pkg::RADIX_W-1:0] t;
		logic [sitrd_pkg::DIGIT_W-1:0] r;
		r = rem_in;
		res.quo = '0;
		for (int k = sitrd_pkg::DIV_BITS - 1; k >= 0; k--) begin
			t = {r, bits[k]};
			if (t >= radix) begin
				t = t - radix;
				res.quo[k] = 1'b1;
			end
			r = t[sitrd_pkg::DIGIT_W-1:0];
		end
		res.rem = {1'b0, r};
	end

endmodule

// ----- rtl/signed_int_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits: signed 32-bit number to text in a set radix
// Input stream: one beat carries a signed 32-bit value in s_tdata.
// Output stream: one beat per character, most significant digit first, a
// leading '-' for negatives, m_tlast on the final character of the number.
// Configuration: cfg_we writes register cfg_index (0 radix_length,
// 1 symbols_low, 2 symbols_high). An alphabet with fewer than two
// symbols or more than MAX_SYMBOLS, a '+' or '-', or a repeated symbol
// gives no output beats. A microcoded sequencer runs the conversion.
// Each digit takes a division set-up, division over 8-bit chunks of the
// magnitude (8 quotient bits a cycle) and a push onto the digit stack.
// Each output character then takes a stack read and an emit; radix 2 on
// the most negative value takes the longest.
// Only one number is in flight; s_tready is high in the idle step alone.
// A stalled receiver holds the output register and freezes the sequencer
// at its emit step. Reset clears configuration and returns to idle.
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits #(
	parameter int MAX_SYMBOLS = sitrd_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sitrd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sitrd_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic signed [sitrd_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sitrd_pkg::SYM_W-1:0]         m_tdata,   // [7:0] symbol
	output logic                                m_tlast
);

	logic [sitrd_pkg::RADIX_W-1:0]  radix_length_q;
	logic [sitrd_pkg::CFG_W-1:0]    symbols_low_q;
	logic [sitrd_pkg::CFG_W-1:0]    symbols_high_q;
	logic                           alpha_ok_q;

	logic [sitrd_pkg::PC_W-1:0]     pc_q;
	logic [sitrd_pkg::VALUE_W-1:0]  mag_q;
	logic                           neg_q;
	logic [sitrd_pkg::COUNT_W-1:0]  count_q;
	logic [sitrd_pkg::CHUNK_W-1:0]  chunk_q;
	logic [sitrd_pkg::DIGIT_W-1:0]  rem_q;
	logic [sitrd_pkg::DIGIT_W-1:0]  rdata_q;
	logic [sitrd_pkg::DIGIT_W-1:0]  stack_q [sitrd_pkg::STACK_DEPTH];

	logic                           m_tvalid_q;
	logic [sitrd_pkg::SYM_W-1:0]    m_tdata_q;
	logic                           m_tlast_q;

	sitrd_pkg::uword_t              uw;
	sitrd_pkg::div_res_t            div_res;
	logic [sitrd_pkg::NSYM*sitrd_pkg::SYM_W-1:0] symbols;
	logic [sitrd_pkg::COUNT_W-1:0]  count_dec;
	logic                           accept;
	logic                           slot_free;
	logic                           is_emit;
	logic                           hold;
	logic                           take;

	assign uw        = sitrd_pkg::ucode(pc_q);
	assign symbols   = {symbols_high_q, symbols_low_q};
	assign count_dec = count_q - 1'b1;
	assign s_tready  = (uw.op == sitrd_pkg::OP_WAIT_IN);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign is_emit   = (uw.op == sitrd_pkg::OP_EMIT_SIGN) ||
		(uw.op == sitrd_pkg::OP_EMIT_DIGIT);
	assign hold      = (uw.op == sitrd_pkg::OP_WAIT_IN && !accept) ||
		(is_emit && !slot_free);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	sitrd_div_chunk u_div (
		.rem_in (rem_q),
		.bits   (mag_q[sitrd_pkg::VALUE_W-1 -: sitrd_pkg::DIV_BITS]),
		.radix  (radix_length_q),
		.res    (div_res)
	);

	always_comb begin
		case (uw.jump)
			sitrd_pkg::J_NEXT:        take = 1'b0;
			sitrd_pkg::J_ALWAYS:      take = 1'b1;
			sitrd_pkg::J_INVALID:     take = !alpha_ok_q;
			sitrd_pkg::J_CHUNK_MORE:
				take = (chunk_q != sitrd_pkg::CHUNK_W'(sitrd_pkg::DIV_CHUNKS - 1));
			sitrd_pkg::J_MORE_DIGITS:
				take = (mag_q != '0) &&
					(count_q != sitrd_pkg::COUNT_W'(sitrd_pkg::STACK_DEPTH - 1));
			sitrd_pkg::J_POSITIVE:    take = !neg_q;
			sitrd_pkg::J_EMPTY:       take = (count_q == '0);
			default:                  take = 1'b0;
		endcase
	end

	// configuration registers and alphabet check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_length_q <= '0;
			symbols_low_q  <= '0;
			symbols_high_q <= '0;
			alpha_ok_q     <= 1'b0;
		end else begin
			alpha_ok_q <= sitrd_pkg::alphabet_ok(radix_length_q, symbols,
				sitrd_pkg::RADIX_W'(MAX_SYMBOLS));
			if (cfg_we) begin
				case (cfg_index)
					sitrd_pkg::REG_RADIX_LENGTH:
						radix_length_q <= cfg_wdata[sitrd_pkg::RADIX_W-1:0];
					sitrd_pkg::REG_SYMBOLS_LOW:  symbols_low_q  <= cfg_wdata;
					sitrd_pkg::REG_SYMBOLS_HIGH: symbols_high_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// sequencer and control datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= sitrd_pkg::PC_IDLE;
			mag_q      <= '0;
			neg_q      <= 1'b0;
			count_q    <= '0;
			chunk_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (hold)
				pc_q <= pc_q;
			else if (take)
				pc_q <= uw.target;
			else
				pc_q <= pc_q + 1'b1;

			if (is_emit && slot_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			case (uw.op)
				sitrd_pkg::OP_WAIT_IN: begin
					if (accept) begin
						neg_q <= s_tdata[sitrd_pkg::VALUE_W-1];
						mag_q <= s_tdata[sitrd_pkg::VALUE_W-1] ?
							(sitrd_pkg::VALUE_W'(0) - sitrd_pkg::VALUE_W'(s_tdata)) :
							sitrd_pkg::VALUE_W'(s_tdata);
					end
				end
				sitrd_pkg::OP_CLEAR:    count_q <= '0;
				sitrd_pkg::OP_DIV_INIT: chunk_q <= '0;
				sitrd_pkg::OP_DIV: begin
					mag_q   <= {mag_q[sitrd_pkg::VALUE_W-sitrd_pkg::DIV_BITS-1:0],
						div_res.quo};
					chunk_q <= chunk_q + 1'b1;
				end
				sitrd_pkg::OP_PUSH:     count_q <= count_q + 1'b1;
				sitrd_pkg::OP_POP: begin
					if (count_q != '0)
						count_q <= count_dec;
				end
				default: ;
			endcase
		end
	end

	// payload: remainder, output character, digit stack
	always_ff @(posedge clk) begin
		case (uw.op)
			sitrd_pkg::OP_DIV_INIT: rem_q <= '0;
			sitrd_pkg::OP_DIV:      rem_q <= div_res.rem[sitrd_pkg::DIGIT_W-1:0];
			sitrd_pkg::OP_PUSH:
				stack_q[count_q[sitrd_pkg::STACK_AW-1:0]] <= rem_q;
			sitrd_pkg::OP_POP:
				rdata_q <= stack_q[count_dec[sitrd_pkg::STACK_AW-1:0]];
			sitrd_pkg::OP_EMIT_SIGN: begin
				if (slot_free) begin
					m_tdata_q <= sitrd_pkg::CH_MINUS;
					m_tlast_q <= (count_q == '0);
				end
			end
			sitrd_pkg::OP_EMIT_DIGIT: begin
				if (slot_free) begin
					m_tdata_q <= symbols[{rdata_q, 3'b000} +: sitrd_pkg::SYM_W];
					m_tlast_q <= (count_q == '0);
				end
			end
			default: ;
		endcase
	end

endmodule
